### rtl/hsvc_pkg.sv
// hsvc_pkg: shared types and constants of the hsv to rgb pixel converter
// no dependencies; imported by the channel interfaces and every rtl module
`default_nettype none

package hsvc_pkg;

   // field widths of one beat
   localparam int HUE_W = 16;
   localparam int PCT_W = 7;
   localparam int CHAN_W = 8;

   // pipeline depth
   localparam int NUM_STAGES = 5;

   // percent ceiling and sector span
   localparam int PERCENT_FULL = 100;
   localparam int HUE_SECTOR_SPAN = 60;
   localparam int SECTORS_PER_TURN = 6;

   // floor(hue / 60) = (hue * 69906) >> 22, exact for 16-bit hue
   localparam int RECIP_60_HUE = 69906;
   localparam int RECIP_60_HUE_SHIFT = 22;
   // floor(v * 255 / 100) = (v * 5347860) >> 21, exact for v <= 100
   localparam int HI_SCALE = 5347860;
   localparam int HI_SHIFT = 21;
   // floor(q / 6) = (q * 1366) >> 13, exact for q < 1093
   localparam int RECIP_6 = 1366;
   localparam int RECIP_6_SHIFT = 13;
   // floor(x / 100) = (x * 20972) >> 21, exact for x <= 25500
   localparam int RECIP_100 = 20972;
   localparam int RECIP_100_SHIFT = 21;
   // floor(x / 60) = (x * 17477) >> 20, exact for x <= 15045
   localparam int RECIP_60_ADJ = 17477;
   localparam int RECIP_60_ADJ_SHIFT = 20;

   // which channel ramps in each 60-degree sector
   typedef enum logic [2:0] {
      SECTOR_GREEN_UP = 3'd0,
      SECTOR_RED_DOWN = 3'd1,
      SECTOR_BLUE_UP  = 3'd2,
      SECTOR_GREEN_DOWN = 3'd3,
      SECTOR_RED_UP   = 3'd4,
      SECTOR_BLUE_DOWN = 3'd5
   } sector_type;

   // per-stage load enables and occupancy
   typedef struct packed {
      logic [NUM_STAGES-1:0] enable;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

endpackage

`default_nettype wire

### rtl/hsvc_req_if.sv
// hsvc_req_if: input channel carrying one hsv pixel per beat
// depends on hsvc_pkg for field widths
`default_nettype none

interface hsvc_req_if
   import hsvc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [PCT_W-1:0]  saturation;
   logic [PCT_W-1:0]  brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

`default_nettype wire

### rtl/hsvc_rsp_if.sv
// hsvc_rsp_if: result channel carrying one rgb triple per beat
// depends on hsvc_pkg for field widths
`default_nettype none

interface hsvc_rsp_if
   import hsvc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### rtl/hsvc_pipe_ctrl.sv
// hsvc_pipe_ctrl: valid bits and per-stage load enables of the pixel pipeline
// depends on hsvc_pkg (NUM_STAGES, pipe_ctrl_type)
`default_nettype none

module hsvc_pipe_ctrl
   import hsvc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   output logic         out_valid,
   input  wire logic    out_ready,
   output pipe_ctrl_type ctrl
);

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] enable;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      enable[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         enable[i] = !valid_ff[i] || enable[i+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in = valid_ff;
      if (enable[0]) begin
         valid_in[0] = in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (enable[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready     = enable[0];
   assign out_valid    = valid_ff[NUM_STAGES-1];
   assign ctrl.enable  = enable;
   assign ctrl.valid   = valid_ff;

   // an empty output stage never holds back the input
   assert property (@(posedge clock) disable iff (reset)
      !valid_ff[NUM_STAGES-1] |-> in_ready)
      else $error("input stalled with empty output stage");

   // an accepted beat lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> valid_ff[0])
      else $error("accepted beat not captured");

   // beats in flight change only by those accepted and delivered
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid_ff) == $past($countones(valid_ff))
                + int'($past(in_valid && in_ready))
                - int'($past(out_valid && out_ready))))
      else $error("beat lost or repeated in pipeline");

endmodule

`default_nettype wire

### rtl/hsvc_datapath.sv
// hsvc_datapath: five register stages from hsv percent to 8-bit rgb
// depends on hsvc_pkg (constants, sector_type, pipe_ctrl_type)
`default_nettype none

module hsvc_datapath
   import hsvc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pipe_ctrl_type     ctrl,
   input  wire logic [HUE_W-1:0]  hue,
   input  wire logic [PCT_W-1:0]  saturation,
   input  wire logic [PCT_W-1:0]  brightness,
   output logic [CHAN_W-1:0]      red,
   output logic [CHAN_W-1:0]      green,
   output logic [CHAN_W-1:0]      blue
);

   localparam int QW = 11;    // floor(hue / 60) up to 1092
   localparam int Q6W = 8;    // floor(q / 6) up to 182
   localparam int OFFW = 6;   // offset within a sector
   localparam int PRODW = 15; // hi * (100 - s) up to 25500
   localparam int PW = 14;    // (hi - lo) * offset up to 15045

   // stage 0: clamp, sector index and max level
   logic [PCT_W-1:0]  sat_clamp;
   logic [PCT_W-1:0]  val_clamp;
   logic [32:0]       hue_prod;
   logic [28:0]       hi_prod;
   logic [HUE_W-1:0]  hue0_ff;
   logic [QW-1:0]     q0_in, q0_ff;
   logic [PCT_W-1:0]  sat0_ff;
   logic [CHAN_W-1:0] hi0_in, hi0_ff;

   always_comb begin
      sat_clamp = (saturation > PCT_W'(PERCENT_FULL)) ? PCT_W'(PERCENT_FULL) : saturation;
      val_clamp = (brightness > PCT_W'(PERCENT_FULL)) ? PCT_W'(PERCENT_FULL) : brightness;
      hue_prod  = 33'(hue) * 33'(RECIP_60_HUE);
      hi_prod   = 29'(val_clamp) * 29'(HI_SCALE);
      q0_in     = QW'(hue_prod >> RECIP_60_HUE_SHIFT);
      hi0_in    = CHAN_W'(hi_prod >> HI_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (ctrl.enable[0]) begin
         hue0_ff <= hue;
         q0_ff   <= q0_in;
         sat0_ff <= sat_clamp;
         hi0_ff  <= hi0_in;
      end
   end

   // stage 1: offset within sector, q / 6, and hi * (100 - s)
   logic [HUE_W-1:0]  off_full;
   logic [20:0]       q6_prod;
   logic [OFFW-1:0]   off1_ff;
   logic [QW-1:0]     q1_ff;
   logic [Q6W-1:0]    q6_1_in, q6_1_ff;
   logic [PRODW-1:0]  prod1_in, prod1_ff;
   logic [CHAN_W-1:0] hi1_ff;

   always_comb begin
      off_full = hue0_ff - HUE_W'(HUE_W'(q0_ff) * HUE_W'(HUE_SECTOR_SPAN));
      q6_prod  = 21'(q0_ff) * 21'(RECIP_6);
      q6_1_in  = Q6W'(q6_prod >> RECIP_6_SHIFT);
      prod1_in = PRODW'(hi0_ff) * PRODW'(PCT_W'(PERCENT_FULL) - sat0_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.enable[1]) begin
         off1_ff  <= off_full[OFFW-1:0];
         q1_ff    <= q0_ff;
         q6_1_ff  <= q6_1_in;
         prod1_ff <= prod1_in;
         hi1_ff   <= hi0_ff;
      end
   end

   // stage 2: sector from q mod 6, min level
   logic [QW-1:0]     sec_full;
   logic [28:0]       lo_prod;
   sector_type        sec2_ff;
   logic [OFFW-1:0]   off2_ff;
   logic [CHAN_W-1:0] hi2_ff;
   logic [CHAN_W-1:0] lo2_in, lo2_ff;

   always_comb begin
      sec_full = q1_ff - QW'(QW'(q6_1_ff) * QW'(SECTORS_PER_TURN));
      lo_prod  = 29'(prod1_ff) * 29'(RECIP_100);
      lo2_in   = CHAN_W'(lo_prod >> RECIP_100_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (ctrl.enable[2]) begin
         sec2_ff <= sector_type'(sec_full[2:0]);
         off2_ff <= off1_ff;
         hi2_ff  <= hi1_ff;
         lo2_ff  <= lo2_in;
      end
   end

   // stage 3: ramp product (hi - lo) * offset
   logic [CHAN_W-1:0] span;
   logic [PW-1:0]     p3_in, p3_ff;
   sector_type        sec3_ff;
   logic [CHAN_W-1:0] hi3_ff;
   logic [CHAN_W-1:0] lo3_ff;

   always_comb begin
      span  = hi2_ff - lo2_ff;
      p3_in = PW'(span) * PW'(off2_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.enable[3]) begin
         p3_ff   <= p3_in;
         sec3_ff <= sec2_ff;
         hi3_ff  <= hi2_ff;
         lo3_ff  <= lo2_ff;
      end
   end

   // stage 4: ramp amount and channel assignment
   logic [27:0]       adj_prod;
   logic [CHAN_W-1:0] adj;
   logic [CHAN_W-1:0] up;
   logic [CHAN_W-1:0] down;
   logic [CHAN_W-1:0] red_in, green_in, blue_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      adj_prod = 28'(p3_ff) * 28'(RECIP_60_ADJ);
      adj      = CHAN_W'(adj_prod >> RECIP_60_ADJ_SHIFT);
      up       = lo3_ff + adj;
      down     = hi3_ff - adj;
      case (sec3_ff)
         SECTOR_GREEN_UP: begin
            red_in = hi3_ff; green_in = up;     blue_in = lo3_ff;
         end
         SECTOR_RED_DOWN: begin
            red_in = down;   green_in = hi3_ff; blue_in = lo3_ff;
         end
         SECTOR_BLUE_UP: begin
            red_in = lo3_ff; green_in = hi3_ff; blue_in = up;
         end
         SECTOR_GREEN_DOWN: begin
            red_in = lo3_ff; green_in = down;   blue_in = hi3_ff;
         end
         SECTOR_RED_UP: begin
            red_in = up;     green_in = lo3_ff; blue_in = hi3_ff;
         end
         default: begin
            red_in = hi3_ff; green_in = lo3_ff; blue_in = down;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.enable[4]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

   // offset stays inside one sector
   assert property (@(posedge clock) disable iff (reset)
      ctrl.valid[2] |-> (off2_ff < OFFW'(HUE_SECTOR_SPAN)))
      else $error("sector offset out of range");

   // sector index is one of six
   assert property (@(posedge clock) disable iff (reset)
      ctrl.valid[2] |-> (sec2_ff <= SECTOR_BLUE_DOWN))
      else $error("sector index out of range");

   // min level never exceeds max level
   assert property (@(posedge clock) disable iff (reset)
      ctrl.valid[3] |-> (lo3_ff <= hi3_ff))
      else $error("min level above max level");

endmodule

`default_nettype wire

### rtl/hsv_to_rgb_pixel_converter_unit.sv
// hsv_to_rgb_pixel_converter_unit: top level of the hsv to rgb pixel converter
// depends on hsvc_pkg, hsvc_req_if, hsvc_rsp_if, hsvc_pipe_ctrl, hsvc_datapath
//
//   channel       | dir | beat contents
//   --------------+-----+------------------------------------------
//   req_channel   | in  | hue[15:0], saturation[6:0], brightness[6:0]
//   rsp_channel   | out | red[7:0], green[7:0], blue[7:0]
//
// five register stages; a beat is registered in stages 0 through 4 in order before its pixel
// appears on rsp_channel, and one pixel per cycle flows through when unstalled.
// each stage has its own valid bit and loads when empty or draining, so
// bubbles are squeezed out while the output waits.
// reset clears only the valid bits; the data registers are not reset.
`default_nettype none

module hsv_to_rgb_pixel_converter_unit
   import hsvc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   hsvc_req_if.sink   req_channel,
   hsvc_rsp_if.source rsp_channel
);

   pipe_ctrl_type ctrl;

   // stage valid bits and load enables
   hsvc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_channel.valid),
      .in_ready  (req_channel.ready),
      .out_valid (rsp_channel.valid),
      .out_ready (rsp_channel.ready),
      .ctrl      (ctrl)
   );

   // arithmetic stages
   hsvc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .hue        (req_channel.hue),
      .saturation (req_channel.saturation),
      .brightness (req_channel.brightness),
      .red        (rsp_channel.red),
      .green      (rsp_channel.green),
      .blue       (rsp_channel.blue)
   );

endmodule

`default_nettype wire

### test/hsv_pixel_checker.sv
// hsv_pixel_checker: watches both channels of the hsv to rgb converter,
// predicts each rgb pixel from the accepted hsv beat and compares in order
// depends on hsvc_pkg for widths, sector codes and arithmetic constants
`timescale 1ns / 100ps

module hsv_pixel_checker
   import hsvc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [HUE_W-1:0]  req_hue,
   input  wire logic [PCT_W-1:0]  req_saturation,
   input  wire logic [PCT_W-1:0]  req_brightness,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [CHAN_W-1:0] rsp_red,
   input  wire logic [CHAN_W-1:0] rsp_green,
   input  wire logic [CHAN_W-1:0] rsp_blue,
   output int unsigned            fail_count,
   output int unsigned            pending_count
);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_pixel_type;

   localparam int unsigned FULL_TURN = HUE_SECTOR_SPAN * SECTORS_PER_TURN;
   localparam int unsigned CHAN_FULL = (1 << CHAN_W) - 1;

   rgb_pixel_type expected_pixels[$];

   // exact integer hsv to rgb conversion with floor division
   function automatic rgb_pixel_type hsv_to_rgb(input logic [HUE_W-1:0] hue,
                                                input logic [PCT_W-1:0] sat,
                                                input logic [PCT_W-1:0] bright);
      int unsigned angle;
      int unsigned offset;
      int unsigned s;
      int unsigned v;
      int unsigned top_level;
      int unsigned floor_level;
      int unsigned ramp;
      sector_type sector;
      rgb_pixel_type px;
      // percentages clamp at full scale
      s = (sat > PERCENT_FULL) ? PERCENT_FULL : sat;
      v = (bright > PERCENT_FULL) ? PERCENT_FULL : bright;
      angle = hue % FULL_TURN;
      sector = sector_type'(angle / HUE_SECTOR_SPAN);
      offset = angle % HUE_SECTOR_SPAN;
      top_level = (v * CHAN_FULL) / PERCENT_FULL;
      floor_level = (top_level * (PERCENT_FULL - s)) / PERCENT_FULL;
      ramp = ((top_level - floor_level) * offset) / HUE_SECTOR_SPAN;
      case (sector)
         SECTOR_GREEN_UP: begin
            px.red = CHAN_W'(top_level);   px.green = CHAN_W'(floor_level + ramp);
            px.blue = CHAN_W'(floor_level);
         end
         SECTOR_RED_DOWN: begin
            px.red = CHAN_W'(top_level - ramp);   px.green = CHAN_W'(top_level);
            px.blue = CHAN_W'(floor_level);
         end
         SECTOR_BLUE_UP: begin
            px.red = CHAN_W'(floor_level);   px.green = CHAN_W'(top_level);
            px.blue = CHAN_W'(floor_level + ramp);
         end
         SECTOR_GREEN_DOWN: begin
            px.red = CHAN_W'(floor_level);   px.green = CHAN_W'(top_level - ramp);
            px.blue = CHAN_W'(top_level);
         end
         SECTOR_RED_UP: begin
            px.red = CHAN_W'(floor_level + ramp);   px.green = CHAN_W'(floor_level);
            px.blue = CHAN_W'(top_level);
         end
         default: begin
            px.red = CHAN_W'(top_level);   px.green = CHAN_W'(floor_level);
            px.blue = CHAN_W'(top_level - ramp);
         end
      endcase
      return px;
   endfunction

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   // predict on accepted input beats, compare on accepted result beats
   always @(posedge clock) begin
      rgb_pixel_type want;
      if (reset) begin
         expected_pixels.delete();
      end else begin
         if (req_valid && req_ready)
            expected_pixels.push_back(hsv_to_rgb(req_hue, req_saturation, req_brightness));
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected rgb beat r=%0d g=%0d b=%0d",
                           $time, rsp_red, rsp_green, rsp_blue);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_red !== want.red || rsp_green !== want.green ||
                   rsp_blue !== want.blue) begin
                  if (fail_count < 10)
                     $display("%0t: rgb mismatch expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                              $time, want.red, want.green, want.blue,
                              rsp_red, rsp_green, rsp_blue);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_pixels.size();
   end

endmodule

### test/tb_top.sv
// tb_top: clock, reset and hsv stimulus for hsv_to_rgb_pixel_converter_unit,
// with random idling on both channels and the final verdict
// depends on hsvc_pkg, hsvc_req_if, hsvc_rsp_if, the unit and hsv_pixel_checker
`timescale 1ns / 100ps

module tb_top;
   import hsvc_pkg::*;

   localparam int unsigned RANDOM_PIXELS = 1750;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned FULL_TURN = HUE_SECTOR_SPAN * SECTORS_PER_TURN;

   logic clock;
   logic reset;
   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit src_idle_mode = 1'b0;
   bit sink_idle_mode = 1'b0;

   hsvc_req_if req_channel();
   hsvc_rsp_if rsp_channel();

   hsv_to_rgb_pixel_converter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .rsp_channel (rsp_channel)
   );

   hsv_pixel_checker pixel_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_channel.valid),
      .req_ready      (req_channel.ready),
      .req_hue        (req_channel.hue),
      .req_saturation (req_channel.saturation),
      .req_brightness (req_channel.brightness),
      .rsp_valid      (rsp_channel.valid),
      .rsp_ready      (rsp_channel.ready),
      .rsp_red        (rsp_channel.red),
      .rsp_green      (rsp_channel.green),
      .rsp_blue       (rsp_channel.blue),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // idle lengths: mostly none or short, a few long
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // hue: full range, one turn, or sector edges in any turn
   function automatic logic [HUE_W-1:0] pick_hue();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) return HUE_W'($urandom_range(0, 65535));
      if (r < 7) return HUE_W'($urandom_range(0, FULL_TURN - 1));
      return HUE_W'(FULL_TURN * $urandom_range(0, 181)
                    + HUE_SECTOR_SPAN * $urandom_range(0, 5)
                    + ($urandom_range(0, 1) ? HUE_SECTOR_SPAN - 1 : 0));
   endfunction

   // percent: mostly in range, some clamped values and edges
   function automatic logic [PCT_W-1:0] pick_percent();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return PCT_W'($urandom_range(0, PERCENT_FULL));
      if (r < 8) return PCT_W'($urandom_range(0, 1) ? PERCENT_FULL : 0);
      return PCT_W'($urandom_range(0, (1 << PCT_W) - 1));
   endfunction

   // one input beat, with an optional idle stretch in front
   task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                             input logic [PCT_W-1:0] bright);
      int unsigned gap;
      if ($urandom_range(0, 79) == 0)
         src_idle_mode = !src_idle_mode;
      gap = src_idle_mode ? gap_length() : 0;
      if (gap != 0) begin
         req_channel.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_channel.valid <= 1'b1;
      req_channel.hue <= hue;
      req_channel.saturation <= sat;
      req_channel.brightness <= bright;
      @(posedge clock);
      while (!req_channel.ready) @(posedge clock);
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0)
         sink_idle_mode <= !sink_idle_mode;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_channel.ready <= 1'b0;
      end else begin
         rsp_channel.ready <= 1'b1;
         if (sink_idle_mode && $urandom_range(0, 3) == 0)
            stall_left <= gap_length();
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[hsv_to_rgb_pixel_converter_unit] ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_channel.valid = 1'b0;
      req_channel.hue = '0;
      req_channel.saturation = '0;
      req_channel.brightness = '0;
      rsp_channel.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: sector edges, hue wrap, clamped and zero percentages
      send_pixel(0, 100, 100);
      send_pixel(59, 100, 100);
      send_pixel(60, 100, 100);
      send_pixel(119, 100, 100);
      send_pixel(120, 100, 100);
      send_pixel(179, 100, 100);
      send_pixel(180, 100, 100);
      send_pixel(239, 100, 100);
      send_pixel(240, 100, 100);
      send_pixel(299, 100, 100);
      send_pixel(300, 100, 100);
      send_pixel(359, 100, 100);
      send_pixel(360, 100, 100);
      send_pixel(750, 50, 75);
      send_pixel(16'hFFFF, 127, 127);
      send_pixel(65519, 101, 101);
      send_pixel(200, 0, 100);
      send_pixel(30, 0, 0);
      send_pixel(90, 100, 0);
      send_pixel(150, 127, 1);
      send_pixel(330, 1, 127);
      send_pixel(16'h8000, 64, 64);
      send_pixel(16'h7FFF, 99, 99);

      // random pixels
      for (int unsigned i = 0; i < RANDOM_PIXELS; i++)
         send_pixel(pick_hue(), pick_percent(), pick_percent());
      req_channel.valid <= 1'b0;

      // drain, then keep watching for stray beats
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (NUM_STAGES * 4) @(posedge clock);
      if (fail_count == 0)
         $display("[hsv_to_rgb_pixel_converter_unit] OK");
      else
         $display("[hsv_to_rgb_pixel_converter_unit] ERROR");
      $finish;
   end

endmodule

### hsv_to_rgb_pixel_converter_unit.f
rtl/hsvc_pkg.sv
rtl/hsvc_req_if.sv
rtl/hsvc_rsp_if.sv
rtl/hsvc_pipe_ctrl.sv
rtl/hsvc_datapath.sv
rtl/hsv_to_rgb_pixel_converter_unit.sv
test/hsv_pixel_checker.sv
test/tb_top.sv
